// ----- rtl/cspr_pkg.sv -----
// Shared types and constants for the cubic spline particle remesh block.
// Holds the beat payload structs, the sequencer state type and register indexes.
// No dependencies.
package cspr_pkg;

	localparam int ACC_W  = 48;
	localparam int NCNT_W = 13;
	localparam int CFG_W  = 32;
	localparam int CIDX_W = 3;

	// ceil(2^19 / 3): floor(y / 3) == (y * RECIP3) >> 19 for y < 2^19
	localparam logic signed [33:0] RECIP3 = 34'sd174763;

	localparam logic [CIDX_W-1:0] CFG_X_LOW  = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_Y_LOW  = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_CELL   = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_INV    = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_NCOL   = 3'd4;
	localparam logic [CIDX_W-1:0] CFG_NROW   = 3'd5;
	localparam logic [CIDX_W-1:0] CFG_THRESH = 3'd6;

	typedef struct packed {
		logic               func;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] strength;
	} in_t;

	typedef struct packed {
		logic signed [31:0] node_x;
		logic signed [31:0] node_y;
		logic signed [31:0] node_value;
		logic               done_res;
		logic [NCNT_W-1:0]  node_count;
	} out_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_AX_T,
		ST_AX_F,
		ST_AX_F2,
		ST_AX_F3,
		ST_AX_G2,
		ST_AX_G3,
		ST_AX_WT,
		ST_NODE_W,
		ST_NODE_S,
		ST_NODE_A,
		ST_DIV,
		ST_D_RD,
		ST_D_EV,
		ST_D_NX,
		ST_D_NY,
		ST_D_OUT,
		ST_D_DONE
	} st_t;

endpackage

// ----- rtl/cspr_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module cspr_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/cspr_mul.sv -----
// Shared signed 34 x 34 multiplier with a registered product.
// No dependencies.
module cspr_mul (
	input  logic               clk,
	input  logic signed [33:0] a,
	input  logic signed [33:0] b,
	output logic signed [67:0] p
);

	logic signed [67:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule

// ----- rtl/cubic_spline_particle_remesh_core.sv -----
// Top level: config registers, sequencer, accumulator grid and result register.
// Depends on cspr_pkg, cspr_ram and cspr_mul.
//
// channel  dir  handshake            payload
// cfg      in   cfg_we               cfg_index, cfg_data
// in       in   in_valid/in_ready    in_data (in_t)
// out      out  out_valid/out_ready  out_data (out_t)
//
// A deposit beat runs the spline weight setup (one multiplier, reused), then walks its
// 4 x 4 support: ST_NODE_W to ST_NODE_A per in-grid node, ST_NODE_W alone per dropped one.
// A drain beat splits the position (ST_DIV), then visits nodes in ST_D_RD and ST_D_EV, a
// kept node also ST_D_NX to ST_D_OUT; one grid port limits the walk.
// After reset the grid is cleared, one entry per cycle, all MAX_COLS * MAX_ROWS of them;
// in_ready stays low meanwhile. A held result only stalls a drain at its final step.
module cubic_spline_particle_remesh_core
	import cspr_pkg::*;
#(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_t               in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_t              out_data
);

	localparam int DEPTH = MAX_COLS * MAX_ROWS;
	localparam int AW    = $clog2(DEPTH);
	localparam int PW    = $clog2(DEPTH + 1);
	localparam int CNW   = $clog2(MAX_COLS + 1);
	localparam int RNW   = $clog2(MAX_ROWS + 1);
	localparam int DCW   = $clog2(PW);
	localparam logic [AW-1:0] MAXR_A = AW'(MAX_ROWS);
	localparam logic [AW-1:0] LAST_A = AW'(DEPTH - 1);

	function automatic logic [51:0] spl_num(input logic [1:0] k, input logic [15:0] f,
			input logic [32:0] f2, input logic [47:0] f3);
		logic [51:0] ff, ff2, ff3, r;
		ff  = 52'(f);
		ff2 = 52'(f2);
		ff3 = 52'(f3);
		case (k)
			2'd1:    r = 3 * ff3 + (52'd1 << 50) - ((6 * ff2) << 16);
			2'd2:    r = ((3 * ff2) << 16) + ((3 * ff) << 32) + (52'd1 << 48) - 3 * ff3;
			default: r = ff3;
		endcase
		return r;
	endfunction

	// round(num / (6 * 2^32)) = floor((num + 3 * 2^32) / 2^33 / 3); this gives the /2^33 part
	function automatic logic signed [33:0] spl_half(input logic [51:0] num);
		logic [51:0] t;
		t = num + (52'd3 << 32);
		return $signed({15'b0, t[51:33]});
	endfunction

	function automatic logic [31:0] sat32(input logic signed [48:0] v);
		logic [31:0] r;
		if (v > 49'sd2147483647) begin
			r = 32'h7FFF_FFFF;
		end else if (v < -49'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// configuration
	logic [31:0] x_low_q, y_low_q;
	logic [30:0] cell_q, inv_q, thr_q;
	logic [6:0]  ncol_q, nrow_q;

	// control
	st_t              state_q, state_d;
	logic [AW-1:0]    clr_q;
	logic [PW-1:0]    pos_q;
	logic [NCNT_W-1:0] cnt_q;
	logic [1:0]       k_q;
	logic             axis_q;
	logic [3:0]       ab_q;
	logic [DCW-1:0]   div_cnt_q;
	logic             out_valid_q;

	// payload
	in_t              item_q;
	logic [15:0]      f_q;
	logic [32:0]      f2_q;
	logic [47:0]      f3_q;
	logic [33:0]      bx_q, by_q;
	logic [16:0]      wx_q [4];
	logic [16:0]      wy_q [4];
	logic [AW-1:0]    addr_q;
	logic [PW-1:0]    dvd_q;
	logic [RNW-1:0]   rem_q;
	logic [CNW-1:0]   c_q;
	logic [RNW-1:0]   r_q, er_q;
	logic [ACC_W-1:0] v_q;
	logic [31:0]      nx_q, ny_q;
	out_t             out_q;

	// datapath
	logic signed [33:0] mul_a, mul_b;
	logic signed [67:0] mul_p;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	logic [ACC_W-1:0]   ram_wdata, ram_rdata;
	logic               out_load;
	out_t               out_d;

	cspr_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	cspr_ram #(.WIDTH(ACC_W), .DEPTH(DEPTH)) u_grid (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// effective grid size
	logic [CNW-1:0] cols_eff;
	logic [RNW-1:0] rows_eff;
	logic [PW-1:0]  total;

	always_comb begin
		if (32'(ncol_q) > MAX_COLS) begin
			cols_eff = CNW'(MAX_COLS);
		end else if (ncol_q == 7'd0) begin
			cols_eff = CNW'(1);
		end else begin
			cols_eff = CNW'(ncol_q);
		end
		if (32'(nrow_q) > MAX_ROWS) begin
			rows_eff = RNW'(MAX_ROWS);
		end else if (nrow_q == 7'd0) begin
			rows_eff = RNW'(1);
		end else begin
			rows_eff = RNW'(nrow_q);
		end
		total = PW'(cols_eff) * PW'(rows_eff);
	end

	// derived terms
	logic signed [67:0] s_full, pr_rnd;
	logic [33:0]        base_n, cnode, rnode;
	logic               node_ok, node_last;
	logic [33:0]        pdiff;
	logic [16:0]        g_val;
	logic [16:0]        wgt;
	logic [33:0]        add_v;
	logic signed [48:0] acc_sum;
	logic [ACC_W-1:0]   acc_new;
	logic signed [48:0] rd_ext, mag;
	logic               keep;
	logic [RNW:0]       div_trial;
	logic               div_bit;
	logic [RNW-1:0]     div_rem_n;
	logic [PW-1:0]      div_dvd_n;
	logic [AW-1:0]      dep_addr, drn_addr;
	logic [31:0]        ctr_low;
	logic signed [48:0] ctr_sum;
	logic               slot_free;

	always_comb begin
		s_full  = (mul_p >>> 16) - 68'sd32768;
		base_n  = s_full[49:16] - 34'd1;
		pdiff   = axis_q ? ({{2{item_q.pos_y[31]}}, item_q.pos_y} - {{2{y_low_q[31]}}, y_low_q})
		                 : ({{2{item_q.pos_x[31]}}, item_q.pos_x} - {{2{x_low_q[31]}}, x_low_q});
		g_val   = 17'd65536 - {1'b0, f_q};
		pr_rnd  = mul_p + 68'sd32768;
		wgt     = pr_rnd[32:16];
		add_v   = pr_rnd[49:16];
		rd_ext  = $signed({ram_rdata[ACC_W-1], ram_rdata});
		acc_sum = rd_ext + $signed({{15{add_v[33]}}, add_v});
		if (acc_sum > 49'sd140737488355327) begin
			acc_new = {1'b0, {(ACC_W-1){1'b1}}};
		end else if (acc_sum < -49'sd140737488355328) begin
			acc_new = {1'b1, {(ACC_W-1){1'b0}}};
		end else begin
			acc_new = acc_sum[ACC_W-1:0];
		end
		mag  = rd_ext[48] ? (49'sd0 - rd_ext) : rd_ext;
		keep = mag > $signed({18'b0, thr_q});

		cnode     = bx_q + {32'b0, ab_q[3:2]};
		rnode     = by_q + {32'b0, ab_q[1:0]};
		node_ok   = !cnode[33] && (cnode < 34'(cols_eff)) &&
		            !rnode[33] && (rnode < 34'(rows_eff));
		node_last = (ab_q == 4'hF);
		dep_addr  = AW'(cnode) * MAXR_A + AW'(rnode);
		drn_addr  = AW'(c_q) * MAXR_A + AW'(r_q);

		div_trial = {rem_q, dvd_q[PW-1]};
		div_bit   = (div_trial >= {1'b0, rows_eff});
		div_rem_n = div_bit ? RNW'(div_trial - {1'b0, rows_eff}) : div_trial[RNW-1:0];
		div_dvd_n = {dvd_q[PW-2:0], div_bit};

		// node centre: low + index * cell + cell / 2
		ctr_low = (state_q == ST_D_NY) ? y_low_q : x_low_q;
		ctr_sum = $signed({{17{ctr_low[31]}}, ctr_low}) +
		          $signed({1'b0, mul_p[47:0]}) + $signed({19'b0, cell_q[30:1]});

		slot_free = !out_valid_q || out_ready;
	end

	// sequencer
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = '0;
		ram_raddr = addr_q;
		out_load  = 1'b0;
		out_d     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				if (clr_q == LAST_A) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (!in_data.func) begin
						state_d = ST_AX_T;
					end else if (pos_q >= total) begin
						state_d = ST_D_DONE;
					end else begin
						state_d = ST_DIV;
					end
				end
			end
			ST_AX_T: begin
				mul_a   = $signed(pdiff);
				mul_b   = $signed({3'b0, inv_q});
				state_d = ST_AX_F;
			end
			ST_AX_F: begin
				mul_a   = $signed({18'b0, s_full[15:0]});
				mul_b   = $signed({18'b0, s_full[15:0]});
				state_d = ST_AX_F2;
			end
			ST_AX_F2: begin
				mul_a   = $signed({1'b0, mul_p[32:0]});
				mul_b   = $signed({18'b0, f_q});
				state_d = ST_AX_F3;
			end
			ST_AX_F3: begin
				mul_a   = $signed({17'b0, g_val});
				mul_b   = $signed({17'b0, g_val});
				state_d = ST_AX_G2;
			end
			ST_AX_G2: begin
				mul_a   = $signed({1'b0, mul_p[32:0]});
				mul_b   = $signed({17'b0, g_val});
				state_d = ST_AX_G3;
			end
			ST_AX_G3: begin
				mul_a   = spl_half(mul_p[51:0]);
				mul_b   = RECIP3;
				state_d = ST_AX_WT;
			end
			ST_AX_WT: begin
				if (k_q != 2'd3) begin
					mul_a = spl_half(spl_num(k_q + 2'd1, f_q, f2_q, f3_q));
					mul_b = RECIP3;
				end else begin
					state_d = axis_q ? ST_NODE_W : ST_AX_T;
				end
			end
			ST_NODE_W: begin
				if (node_ok) begin
					mul_a   = $signed({17'b0, wx_q[ab_q[3:2]]});
					mul_b   = $signed({17'b0, wy_q[ab_q[1:0]]});
					state_d = ST_NODE_S;
				end else if (node_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_NODE_S: begin
				mul_a   = $signed({{2{item_q.strength[31]}}, item_q.strength});
				mul_b   = $signed({17'b0, wgt});
				state_d = ST_NODE_A;
			end
			ST_NODE_A: begin
				ram_we    = 1'b1;
				ram_wdata = acc_new;
				state_d   = node_last ? ST_IDLE : ST_NODE_W;
			end
			ST_DIV: begin
				if (div_cnt_q == '0) begin
					state_d = ST_D_RD;
				end
			end
			ST_D_RD: begin
				if (pos_q >= total) begin
					state_d = ST_D_DONE;
				end else begin
					ram_raddr = drn_addr;
					state_d   = ST_D_EV;
				end
			end
			ST_D_EV: begin
				ram_we = 1'b1;
				if (keep) begin
					mul_a   = $signed({(34-CNW)'(0), c_q});
					mul_b   = $signed({3'b0, cell_q});
					state_d = ST_D_NX;
				end else begin
					state_d = ST_D_RD;
				end
			end
			ST_D_NX: begin
				mul_a   = $signed({(34-RNW)'(0), er_q});
				mul_b   = $signed({3'b0, cell_q});
				state_d = ST_D_NY;
			end
			ST_D_NY: begin
				state_d = ST_D_OUT;
			end
			ST_D_OUT: begin
				if (slot_free) begin
					out_load         = 1'b1;
					out_d.node_x     = nx_q;
					out_d.node_y     = ny_q;
					out_d.node_value = sat32($signed({v_q[ACC_W-1], v_q}));
					out_d.done_res   = 1'b0;
					out_d.node_count = cnt_q + 1'b1;
					state_d          = ST_IDLE;
				end
			end
			ST_D_DONE: begin
				if (slot_free) begin
					out_load         = 1'b1;
					out_d.done_res   = 1'b1;
					out_d.node_count = cnt_q;
					state_d          = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			pos_q       <= '0;
			cnt_q       <= '0;
			k_q         <= '0;
			axis_q      <= 1'b0;
			ab_q        <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			x_low_q     <= 32'hFFFE_6666;
			y_low_q     <= 32'hFFFE_6666;
			cell_q      <= 31'd3277;
			inv_q       <= 31'd1310720;
			ncol_q      <= 7'd64;
			nrow_q      <= 7'd64;
			thr_q       <= 31'd7;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_X_LOW:  x_low_q <= cfg_data;
					CFG_Y_LOW:  y_low_q <= cfg_data;
					CFG_CELL:   cell_q  <= cfg_data[30:0];
					CFG_INV:    inv_q   <= cfg_data[30:0];
					CFG_NCOL:   ncol_q  <= cfg_data[6:0];
					CFG_NROW:   nrow_q  <= cfg_data[6:0];
					CFG_THRESH: thr_q   <= cfg_data[30:0];
					default: ;
				endcase
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					axis_q    <= 1'b0;
					ab_q      <= '0;
					k_q       <= '0;
					div_cnt_q <= DCW'(PW - 1);
				end
				ST_AX_G3: k_q <= '0;
				ST_AX_WT: begin
					k_q <= k_q + 1'b1;
					if (k_q == 2'd3) begin
						axis_q <= 1'b1;
					end
				end
				ST_NODE_W: begin
					if (!node_ok) begin
						ab_q <= ab_q + 1'b1;
					end
				end
				ST_NODE_A: ab_q <= ab_q + 1'b1;
				ST_DIV: div_cnt_q <= div_cnt_q - 1'b1;
				ST_D_EV: pos_q <= pos_q + 1'b1;
				ST_D_OUT: begin
					if (slot_free) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_D_DONE: begin
					if (slot_free) begin
						pos_q <= '0;
						cnt_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= in_data;
			dvd_q  <= pos_q;
			rem_q  <= '0;
		end
		if (out_load) begin
			out_q <= out_d;
		end
		case (state_q)
			ST_AX_F: begin
				f_q <= s_full[15:0];
				if (axis_q) begin
					by_q <= base_n;
				end else begin
					bx_q <= base_n;
				end
			end
			ST_AX_F2: f2_q <= mul_p[32:0];
			ST_AX_F3: f3_q <= mul_p[47:0];
			ST_AX_WT: begin
				if (axis_q) begin
					wy_q[k_q] <= mul_p[35:19];
				end else begin
					wx_q[k_q] <= mul_p[35:19];
				end
			end
			ST_NODE_W: addr_q <= dep_addr;
			ST_DIV: begin
				dvd_q <= div_dvd_n;
				rem_q <= div_rem_n;
				if (div_cnt_q == '0) begin
					c_q <= CNW'(div_dvd_n);
					r_q <= div_rem_n;
				end
			end
			ST_D_RD: addr_q <= drn_addr;
			ST_D_EV: begin
				v_q  <= ram_rdata;
				er_q <= r_q;
				if (r_q + 1'b1 == rows_eff) begin
					r_q <= '0;
					c_q <= c_q + 1'b1;
				end else begin
					r_q <= r_q + 1'b1;
				end
			end
			ST_D_NX: nx_q <= sat32(ctr_sum);
			ST_D_NY: ny_q <= sat32(ctr_sum);
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.done_res |->
			out_data.node_x == 0 && out_data.node_y == 0 && out_data.node_value == 0)
		else $error("done beat carries node data");

	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> ram_we && ram_wdata == '0)
		else $error("grid clear pass wrote nonzero");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second beat taken while busy");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pos_q) <= DEPTH)
		else $error("drain position beyond grid");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !out_valid_q || out_ready)
		else $error("pending result overwritten");

endmodule
